// ===== rtl/core/snks_pkg.sv =====
// Shared types, constants and helpers for the sorted node key search/insert block.
// No dependencies; used by snks_ctrl and sorted_node_key_search_insert.
`default_nettype none

package snks_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int KEY_W       = 64;
	localparam int PAGE_W      = 32;
	localparam int KB_W        = 4;
	localparam int CAP_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 3;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DESCEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_EXISTS     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_MOVE_RIGHT = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHILD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 2'd2;

	localparam logic [KB_W-1:0]  KEY_BYTES_RESET = 4'd8;
	localparam logic [CAP_W-1:0] CAPACITY_RESET  = 9'd256;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [PAGE_W-1:0] child_page;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    position;
		logic [PAGE_W-1:0]   page;
	} rsp_t;

	typedef struct packed {
		logic [KB_W-1:0]   key_bytes;
		logic [PAGE_W-1:0] first_child;
		logic [CAP_W-1:0]  capacity_limit;
	} cfg_t;

	// compare mask over the low key_bytes bytes
	function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
		logic [KEY_W-1:0] m;
		if (kb == '0) begin
			m = '0;
		end else if (kb >= 4'd8) begin
			m = '1;
		end else begin
			m = (KEY_W'(1) << {kb[2:0], 3'b000}) - KEY_W'(1);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/snks_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module snks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/snks_ctrl.sv =====
// Sequencer for search, descend and insert over the node memories.
// Depends on snks_pkg and snks_ram (key, page and sorted-order stores).
`default_nettype none

module snks_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire snks_pkg::cfg_t cfg,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire snks_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_take,
	output snks_pkg::rsp_t      res
);
	import snks_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_ORD,
		S_KEY,
		S_PG_ORD,
		S_PG_DAT,
		S_SH_WR,
		S_SH_LAST,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAGE_W-1:0] child_q;
	logic [CNT_W-1:0]  low_q, low_d, high_q, high_d, mid_q, mid_d;
	logic [CNT_W-1:0]  pos_q, pos_d, count_q, count_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	rsp_t              res_q, res_d;

	// memory ports
	logic              ord_we, key_we, pg_we;
	logic [IDX_W-1:0]  ord_waddr, ord_wdata, ord_raddr, ord_rdata;
	logic [IDX_W-1:0]  key_raddr, pg_raddr;
	logic [KEY_W-1:0]  key_rdata;
	logic [PAGE_W-1:0] pg_rdata;

	// search scratch
	logic [KEY_W-1:0]  mask, srch_key, cmp_key;
	logic [CNT_W-1:0]  low_n, high_n, mid_n, pos_m1, count_m1, idx_m1;
	logic              fin, fin_match, exact, kind_ok, full;
	logic [CNT_W-1:0]  fin_pos;

	snks_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_order (
		.clk(clk), .wr_en(ord_we), .wr_addr(ord_waddr), .wr_data(ord_wdata),
		.rd_addr(ord_raddr), .rd_data(ord_rdata)
	);

	snks_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_keys (
		.clk(clk), .wr_en(key_we), .wr_addr(count_q[IDX_W-1:0]), .wr_data(key_q),
		.rd_addr(key_raddr), .rd_data(key_rdata)
	);

	snks_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_ENTRIES)) u_pages (
		.clk(clk), .wr_en(pg_we), .wr_addr(count_q[IDX_W-1:0]), .wr_data(child_q),
		.rd_addr(pg_raddr), .rd_data(pg_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign mask     = key_mask(cfg.key_bytes);
	assign srch_key = key_q & mask;
	assign cmp_key  = key_rdata & mask;
	assign exact    = (kind_q == KIND_SEARCH) || (kind_q == KIND_INSERT);
	assign kind_ok  = exact || (kind_q == KIND_DESCEND);
	assign count_m1 = count_q - CNT_W'(1);
	assign idx_m1   = CNT_W'(idx_q) - CNT_W'(1);
	assign full     = (32'(count_q) >= 32'(cfg.capacity_limit)) ||
	                  (32'(count_q) >= 32'(MAX_ENTRIES));

	always_comb begin
		state_d   = state_q;
		low_d     = low_q;
		high_d    = high_q;
		mid_d     = mid_q;
		pos_d     = pos_q;
		idx_d     = idx_q;
		count_d   = count_q;
		res_d     = res_q;
		ord_we    = 1'b0;
		ord_waddr = '0;
		ord_wdata = '0;
		ord_raddr = '0;
		key_we    = 1'b0;
		pg_we     = 1'b0;
		key_raddr = '0;
		pg_raddr  = '0;
		fin       = 1'b0;
		fin_match = 1'b0;
		fin_pos   = '0;
		low_n     = low_q;
		high_n    = high_q;
		mid_n     = '0;
		pos_m1    = '0;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (count_q == '0 || !kind_ok) begin
					fin = 1'b1;
				end else begin
					mid_n     = count_q >> 1;
					ord_raddr = mid_n[IDX_W-1:0];
					low_d     = '0;
					high_d    = count_q;
					mid_d     = mid_n;
					state_d   = S_ORD;
				end
			end
			S_ORD: begin
				key_raddr = ord_rdata;
				state_d   = S_KEY;
			end
			S_KEY: begin
				if (srch_key == cmp_key && exact) begin
					fin       = 1'b1;
					fin_match = 1'b1;
					fin_pos   = mid_q;
				end else begin
					// equal keys move right when not matching exactly
					if (srch_key < cmp_key) begin
						high_n = mid_q;
					end else begin
						low_n = mid_q + CNT_W'(1);
					end
					if (low_n == high_n) begin
						fin     = 1'b1;
						fin_pos = high_n;
					end else begin
						mid_n     = low_n + ((high_n - low_n) >> 1);
						ord_raddr = mid_n[IDX_W-1:0];
						low_d     = low_n;
						high_d    = high_n;
						mid_d     = mid_n;
						state_d   = S_ORD;
					end
				end
			end
			S_PG_ORD: begin
				pg_raddr = ord_rdata;
				state_d  = S_PG_DAT;
			end
			S_PG_DAT: begin
				res_d.page = pg_rdata;
				state_d    = S_DONE;
			end
			S_SH_WR: begin
				// write back the entry read last cycle, fetch the next one down
				ord_we    = 1'b1;
				ord_waddr = idx_q;
				ord_wdata = ord_rdata;
				if (idx_m1 > pos_q) begin
					ord_raddr = idx_q - IDX_W'(2);
					idx_d     = idx_q - IDX_W'(1);
				end else begin
					state_d = S_SH_LAST;
				end
			end
			S_SH_LAST: begin
				ord_we    = 1'b1;
				ord_waddr = pos_q[IDX_W-1:0];
				ord_wdata = count_q[IDX_W-1:0];
				count_d   = count_q + CNT_W'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			pos_d          = fin_pos;
			pos_m1         = fin_pos - CNT_W'(1);
			res_d.status   = STATUS_NOT_FOUND;
			res_d.position = fin_pos;
			res_d.page     = '0;
			state_d        = S_DONE;
			case (kind_q)
				KIND_SEARCH: begin
					res_d.status = fin_match ? STATUS_OK : STATUS_NOT_FOUND;
				end
				KIND_DESCEND: begin
					res_d.status = STATUS_OK;
					if (fin_pos == '0) begin
						res_d.page = cfg.first_child;
					end else begin
						ord_raddr = pos_m1[IDX_W-1:0];
						state_d   = S_PG_ORD;
					end
				end
				KIND_INSERT: begin
					if (fin_match) begin
						res_d.status = STATUS_EXISTS;
					end else if (fin_pos == count_q && fin_pos != '0) begin
						res_d.status = STATUS_MOVE_RIGHT;
						ord_raddr    = count_m1[IDX_W-1:0];
						state_d      = S_PG_ORD;
					end else if (full) begin
						res_d.status = STATUS_FULL;
					end else begin
						res_d.status = STATUS_OK;
						key_we       = 1'b1;
						pg_we        = 1'b1;
						if (count_q > fin_pos) begin
							ord_raddr = count_m1[IDX_W-1:0];
							idx_d     = count_q[IDX_W-1:0];
							state_d   = S_SH_WR;
						end else begin
							state_d = S_SH_LAST;
						end
					end
				end
				default: begin
					res_d.position = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			kind_q  <= req.kind;
			key_q   <= req.key;
			child_q <= req.child_page;
		end
		low_q  <= low_d;
		high_q <= high_d;
		mid_q  <= mid_d;
		pos_q  <= pos_d;
		idx_q  <= idx_d;
		res_q  <= res_d;
	end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_node_key_search_insert.sv =====
// Top level of the sorted node key search/insert block: config registers and
// result register around the sequencer. Depends on snks_pkg and snks_ctrl.
//
// One node page of up to 256 keyed entries, kept in arrival slots with a sorted
// slot-order list. Each request transaction runs exact search, descend or insert
// and yields exactly one response transaction. Requests are taken one at a time.
// Every binary-search probe reads the order memory, then the key memory; a
// descend or move-right adds a page lookup (order memory, then page memory),
// and an insert moves each entry above the insert point up in the order list
// before writing the new slot into it. The order-memory port is what bounds
// both the probes and the shift. The response sits in an output register, so
// the next request can start while it waits. Registers are written through
// cfg_write_en/cfg_index/cfg_data only while the block is idle: the user is
// bound to this, the block does not enforce it; index 3 is ignored. No
// clearing pass: memory entries are only read below the entry count.
`default_nettype none

module sorted_node_key_search_insert (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire snks_pkg::req_t                 req,
	// response channel
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output snks_pkg::rsp_t                      rsp,
	// register write port
	input  wire logic                           cfg_write_en,
	input  wire logic [snks_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [snks_pkg::CFG_DATA_W-1:0] cfg_data
);
	import snks_pkg::*;

	cfg_t cfg_q;
	logic res_valid, res_take;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// register file, one write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_bytes      <= KEY_BYTES_RESET;
			cfg_q.first_child    <= '0;
			cfg_q.capacity_limit <= CAPACITY_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_KEY_BYTES:      cfg_q.key_bytes      <= cfg_data[KB_W-1:0];
				CFG_FIRST_CHILD:    cfg_q.first_child    <= cfg_data[PAGE_W-1:0];
				CFG_CAPACITY_LIMIT: cfg_q.capacity_limit <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	snks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// output register: load whenever it is empty or being drained this cycle
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
